[hdl/fbhc_pkg.sv]
// Package for the footswitch bypass hold controller.
// Holds the sequencer phase type, register indexes, reset values and shared structs.
// No dependencies.
package fbhc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned HELD_W     = 16;
	localparam int unsigned STORE_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE_LEAD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE_TAIL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_ON  = 3'd5;

	localparam logic [CNT_W-1:0]   DEBOUNCE_RST  = 8'd15;
	localparam logic [HELD_W-1:0]  HOLD_THR_RST  = 16'd1000;
	localparam logic [CNT_W-1:0]   MUTE_LEAD_RST = 8'd20;
	localparam logic [CNT_W-1:0]   MUTE_TAIL_RST = 8'd20;
	localparam logic [CNT_W-1:0]   SETTLE_RST    = 8'd10;

	localparam logic [HELD_W-1:0]  HELD_MAX      = 16'hFFFF;
	localparam logic [STORE_W-1:0] STORE_ON      = 8'hFF;
	localparam logic [STORE_W-1:0] STORE_OFF     = 8'h00;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DEB_DN = 3'd1,
		PH_DEB_UP = 3'd2,
		PH_LEAD   = 3'd3,
		PH_TAIL   = 3'd4,
		PH_SETTLE = 3'd5
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]  debounce_ticks;
		logic [HELD_W-1:0] hold_threshold;
		logic [CNT_W-1:0]  mute_lead_ticks;
		logic [CNT_W-1:0]  mute_tail_ticks;
		logic [CNT_W-1:0]  settle_ticks;
		logic              start_on;
	} cfg_t;

	typedef struct packed {
		logic               effect_on;
		logic               mute_on;
		logic               hold_active;
		logic               store_write;
		logic [STORE_W-1:0] store_value;
	} res_t;

	function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
		at_least_one = (v == '0) ? CNT_W'(1) : v;
	endfunction

endpackage

[hdl/fbhc_cfg_regs.sv]
// Configuration register bank of the footswitch bypass hold controller.
// Depends on fbhc_pkg for register indexes, reset values and cfg_t.
module fbhc_cfg_regs import fbhc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks  <= DEBOUNCE_RST;
			cfg_q.hold_threshold  <= HOLD_THR_RST;
			cfg_q.mute_lead_ticks <= MUTE_LEAD_RST;
			cfg_q.mute_tail_ticks <= MUTE_TAIL_RST;
			cfg_q.settle_ticks    <= SETTLE_RST;
			cfg_q.start_on        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce_ticks  <= cfg_data[CNT_W-1:0];
				REG_HOLD_THR:  cfg_q.hold_threshold  <= cfg_data[HELD_W-1:0];
				REG_MUTE_LEAD: cfg_q.mute_lead_ticks <= cfg_data[CNT_W-1:0];
				REG_MUTE_TAIL: cfg_q.mute_tail_ticks <= cfg_data[CNT_W-1:0];
				REG_SETTLE:    cfg_q.settle_ticks    <= cfg_data[CNT_W-1:0];
				REG_START_ON:  cfg_q.start_on        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/fbhc_core.sv]
// Switch debounce, hold detection and mute/relay sequencer state.
// Advances one tick per step and returns the result of that tick; depends on fbhc_pkg.
module fbhc_core import fbhc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	input  logic level,
	output res_t res
);

	logic              effect_q, hold_q, last_q, started_q;
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  count_q;
	phase_t            phase_q;

	logic              effect_d, hold_d, last_d, started_d, strobe;
	logic [HELD_W-1:0] held_d;
	logic [CNT_W-1:0]  count_d;
	phase_t            phase_d;
	logic              skip, done;

	always_comb begin
		effect_d  = effect_q;
		hold_d    = hold_q;
		last_d    = last_q;
		started_d = 1'b1;
		held_d    = (held_q == HELD_MAX) ? held_q : held_q + HELD_W'(1);
		count_d   = count_q;
		phase_d   = phase_q;
		strobe    = 1'b0;
		skip      = 1'b0;
		done      = (count_q <= CNT_W'(1));

		if (!started_q && cfg.start_on && !effect_q) begin
			skip    = 1'b1;
			phase_d = PH_LEAD;
			count_d = at_least_one(cfg.mute_lead_ticks);
		end

		if (!skip) begin
			unique case (phase_q)
				PH_DEB_DN: begin
					if (!done) begin
						count_d = count_q - CNT_W'(1);
					end else if (!level) begin
						if (!effect_q)
							held_d = '0;
						phase_d = PH_LEAD;
						count_d = at_least_one(cfg.mute_lead_ticks);
					end else begin
						last_d  = 1'b1;
						phase_d = PH_DEB_UP;
						count_d = at_least_one(cfg.debounce_ticks);
					end
				end
				PH_DEB_UP: begin
					if (!done) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						phase_d = PH_IDLE;
						count_d = '0;
						if (level && hold_q) begin
							hold_d  = 1'b0;
							phase_d = PH_LEAD;
							count_d = at_least_one(cfg.mute_lead_ticks);
						end
					end
				end
				PH_LEAD: begin
					if (!done) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						effect_d = ~effect_q;
						phase_d  = PH_TAIL;
						count_d  = at_least_one(cfg.mute_tail_ticks);
					end
				end
				PH_TAIL: begin
					if (!done) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						strobe = 1'b1;
						if (cfg.settle_ticks == '0) begin
							phase_d = PH_IDLE;
							count_d = '0;
						end else begin
							phase_d = PH_SETTLE;
							count_d = cfg.settle_ticks;
						end
					end
				end
				PH_SETTLE: begin
					if (!done) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						phase_d = PH_IDLE;
						count_d = '0;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					count_d = '0;
					if (!level) begin
						if (last_q) begin
							last_d  = 1'b0;
							phase_d = PH_DEB_DN;
							count_d = at_least_one(cfg.debounce_ticks);
						end else if (effect_q && !hold_q && held_d > cfg.hold_threshold) begin
							hold_d = 1'b1;
						end
					end else if (!last_q) begin
						last_d  = 1'b1;
						phase_d = PH_DEB_UP;
						count_d = at_least_one(cfg.debounce_ticks);
					end
				end
			endcase
		end
	end

	always_comb begin
		res.effect_on   = effect_d;
		res.mute_on     = (phase_d == PH_LEAD) || (phase_d == PH_TAIL);
		res.hold_active = hold_d;
		res.store_write = strobe;
		res.store_value = (strobe && effect_d) ? STORE_ON : STORE_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_q  <= 1'b0;
			hold_q    <= 1'b0;
			last_q    <= 1'b0;
			started_q <= 1'b0;
			held_q    <= '0;
			count_q   <= '0;
			phase_q   <= PH_IDLE;
		end else if (step) begin
			effect_q  <= effect_d;
			hold_q    <= hold_d;
			last_q    <= last_d;
			started_q <= started_d;
			held_q    <= held_d;
			count_q   <= count_d;
			phase_q   <= phase_d;
		end
	end

endmodule

[hdl/footswitch_bypass_hold_controller.sv]
// Footswitch bypass controller with momentary hold: top level.
// Input register, fbhc_core, result register; configuration in fbhc_cfg_regs.
// Depends on fbhc_pkg.
//
// Use: send one word per timer tick on the input channel (in_valid, in_stall,
// switch_level, 0 pressed). Every accepted word yields exactly one result word
// on the output channel (out_valid, out_stall, effect_on, mute_on, hold_active,
// store_write, store_value), in order.
// A word taken into the input register has its result put in the result register
// when that register can take it. Throughput: one word per clock unless stalled.
// The whole tick is worked out by the core between the two registers, and the
// core state advances only when the result register can take the new result.
// While out_stall holds a waiting result, one more word is taken into the input
// register; after that in_stall rises until the result is taken.
// Configuration: cfg_we with cfg_index (0 debounce, 1 hold threshold, 2 mute
// lead, 3 mute tail, 4 settle, 5 start on) and cfg_data, one write per clock.
// Reset (arst_n low): both registers empty, effect off, sequencer idle,
// configuration back to 15, 1000, 20, 20, 10 and 0.
module footswitch_bypass_hold_controller import fbhc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  switch_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  effect_on,
	output logic                  mute_on,
	output logic                  hold_active,
	output logic                  store_write,
	output logic [STORE_W-1:0]    store_value
);

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1, level_s1, valid_s2, advance;

	fbhc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fbhc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (valid_s1 && advance),
		.level  (level_s1),
		.res    (res)
	);

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			level_s1 <= switch_level;
		if (valid_s1 && advance)
			res_s2 <= res;
	end

	assign out_valid   = valid_s2;
	assign effect_on   = res_s2.effect_on;
	assign mute_on     = res_s2.mute_on;
	assign hold_active = res_s2.hold_active;
	assign store_write = res_s2.store_write;
	assign store_value = res_s2.store_value;

endmodule
